>>> hw/rtl/qrs_pkg.sv
// Package for the quadratic root solver: widths, status codes and the
// beat structure handed between the pipeline cells. No dependencies.
package qrs_pkg;

	localparam int CW = 16;              // coefficient width
	localparam int DW = 2 * CW + 2;      // discriminant width (unsigned)
	localparam int SW = CW + 1;          // square root width
	localparam int NW = CW + 2;          // numerator width, signed
	localparam int QW = NW + 16;         // scaled numerator width
	localparam int PW = CW + 1;          // denominator magnitude width
	localparam int RW = 32;              // root width
	localparam int SQ_STEPS = SW;
	localparam int DV_STEPS = QW;
	localparam int SQ_SEL_W = $clog2(SW); // width of a root bit index

	typedef enum logic [1:0] {
		ST_TWO  = 2'd0,
		ST_ONE  = 2'd1,
		ST_NONE = 2'd2,
		ST_NOTQ = 2'd3
	} status_t;

	typedef struct packed {
		logic            vld;
		status_t         status;
		logic signed [CW-1:0] b;
		logic [PW-1:0]   den;     // |2a|
		logic            den_neg;
		logic [DW-1:0]   rem;     // square root remainder
		logic [SW-1:0]   root;
	} sq_beat_t;

	typedef struct packed {
		logic            vld;
		status_t         status;
		logic [PW-1:0]   den;
		logic            p_neg;
		logic            m_neg;
		logic [QW-1:0]   p_num;   // dividend shifted out, MSB first
		logic [QW-1:0]   m_num;
		logic [QW:0]     p_rem;
		logic [QW:0]     m_rem;
		logic [QW-1:0]   p_quo;
		logic [QW-1:0]   m_quo;
	} dv_beat_t;

endpackage

>>> hw/rtl/qrs_sqrt_cell.sv
// One digit step of the restoring square root, registered; step_bit names
// the root bit this cell decides. Depends on qrs_pkg.
module qrs_sqrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [qrs_pkg::SQ_SEL_W-1:0] step_bit,
	input  qrs_pkg::sq_beat_t din,
	output qrs_pkg::sq_beat_t dout
);
	import qrs_pkg::*;

	logic [2*SW+1:0] trial;
	logic [2*SW+1:0] rem_w;
	sq_beat_t nxt;

	always_comb begin
		nxt = din;
		rem_w = {{(2*SW+2-DW){1'b0}}, din.rem};
		trial = (({{(SW+2){1'b0}}, din.root} << (step_bit + 1))
			| ((2*SW+2)'(1) << (2 * step_bit)));
		if (rem_w >= trial) begin
			nxt.rem  = DW'(rem_w - trial);
			nxt.root = din.root | (SW'(1) << step_bit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

>>> hw/rtl/qrs_div_cell.sv
// One bit step of two restoring unsigned divisions sharing a divisor.
// Depends on qrs_pkg.
module qrs_div_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  qrs_pkg::dv_beat_t din,
	output qrs_pkg::dv_beat_t dout
);
	import qrs_pkg::*;

	dv_beat_t nxt;
	logic [QW:0] pr;
	logic [QW:0] mr;
	logic [QW:0] dd;

	always_comb begin
		nxt = din;
		dd = {{(QW+1-PW){1'b0}}, din.den};
		pr = {din.p_rem[QW-1:0], din.p_num[QW-1]};
		mr = {din.m_rem[QW-1:0], din.m_num[QW-1]};
		nxt.p_num = {din.p_num[QW-2:0], 1'b0};
		nxt.m_num = {din.m_num[QW-2:0], 1'b0};
		if (pr >= dd) begin
			nxt.p_rem = pr - dd;
			nxt.p_quo = {din.p_quo[QW-2:0], 1'b1};
		end else begin
			nxt.p_rem = pr;
			nxt.p_quo = {din.p_quo[QW-2:0], 1'b0};
		end
		if (mr >= dd) begin
			nxt.m_rem = mr - dd;
			nxt.m_quo = {din.m_quo[QW-2:0], 1'b1};
		end else begin
			nxt.m_rem = mr;
			nxt.m_quo = {din.m_quo[QW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

>>> hw/rtl/quadratic_root_solver_core.sv
// Top level of the quadratic root solver: front stages, square root and
// divider cell chains, saturation and output. Depends on qrs_pkg and cells.
//
//  channel | direction | tdata fields (low bit first)
//  s_axis  | in        | coef_a[15:0], coef_b[31:16], coef_c[47:32]
//  m_axis  | out       | root_status[1:0], root_plus[33:2], root_minus[65:34]
//
// One beat is taken every cycle while m_axis is not stalled. A beat passes
// the front stages, the square root chain (one cell per root bit), the divider
// chain (one cell per quotient bit) and the output register. The whole chain
// advances only when the output register is empty or being taken, so a stall
// at m_axis holds every stage. Reset clears the valid bits of all stages.
module quadratic_root_solver_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // coef_a, coef_b, coef_c
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata   // root_status, root_plus, root_minus, zero pad
);
	import qrs_pkg::*;

	logic en;
	logic signed [CW-1:0] a_in, b_in, c_in;

	// Stage 1: products.
	logic vld_s1;
	logic signed [CW-1:0] a_s1, b_s1;
	logic [2*CW-1:0] bb_s1, ac_s1;
	logic acpos_s1;
	// Stage 2: discriminant.
	logic vld_s2;
	status_t st_s2;
	logic signed [CW-1:0] a_s2, b_s2;
	logic [DW-1:0] d_s2;

	sq_beat_t sq [SQ_STEPS+1];
	dv_beat_t dv [DV_STEPS+1];

	logic [DW:0] dsum;
	logic [CW-1:0] ma, mb, mc;
	logic signed [NW-1:0] pn, mn;
	logic [NW-1:0] pmag, mmag;
	logic signed [RW-1:0] rp, rm;
	logic vld_q;
	logic [65:0] data_q;

	assign en = !vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign a_in = s_axis_tdata[15:0];
	assign b_in = s_axis_tdata[31:16];
	assign c_in = s_axis_tdata[47:32];
	assign ma = a_in[CW-1] ? CW'(-a_in) : a_in;
	assign mb = b_in[CW-1] ? CW'(-b_in) : b_in;
	assign mc = c_in[CW-1] ? CW'(-c_in) : c_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_in;
			b_s1 <= b_in;
			bb_s1 <= {{CW{1'b0}}, mb} * {{CW{1'b0}}, mb};
			ac_s1 <= {{CW{1'b0}}, ma} * {{CW{1'b0}}, mc};
			acpos_s1 <= (a_in[CW-1] == c_in[CW-1]) && (c_in != '0);
		end
	end

	always_comb begin
		if (acpos_s1) begin
			dsum = {3'b0, bb_s1} - {1'b0, ac_s1, 2'b0};
		end else begin
			dsum = {3'b0, bb_s1} + {1'b0, ac_s1, 2'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			d_s2 <= dsum[DW-1:0];
			if (a_s1 == '0) begin
				st_s2 <= ST_NOTQ;
			end else if (dsum[DW]) begin
				st_s2 <= ST_NONE;
			end else if (dsum == '0) begin
				st_s2 <= ST_ONE;
			end else begin
				st_s2 <= ST_TWO;
			end
		end
	end

	always_comb begin
		sq[0].vld = vld_s2;
		sq[0].status = st_s2;
		sq[0].b = b_s2;
		sq[0].den_neg = a_s2[CW-1];
		sq[0].den = a_s2[CW-1] ? PW'(-{a_s2, 1'b0}) : PW'({a_s2, 1'b0});
		sq[0].rem = (st_s2 == ST_TWO) ? d_s2 : '0;
		sq[0].root = '0;
	end

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		qrs_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.step_bit(SQ_SEL_W'(SQ_STEPS - 1 - i)), .din(sq[i]), .dout(sq[i+1])
		);
	end

	always_comb begin
		pn = -NW'(sq[SQ_STEPS].b) + NW'({1'b0, sq[SQ_STEPS].root});
		mn = -NW'(sq[SQ_STEPS].b) - NW'({1'b0, sq[SQ_STEPS].root});
		pmag = pn[NW-1] ? NW'(-pn) : pn;
		mmag = mn[NW-1] ? NW'(-mn) : mn;
		dv[0].vld = sq[SQ_STEPS].vld;
		dv[0].status = sq[SQ_STEPS].status;
		dv[0].den = sq[SQ_STEPS].den;
		dv[0].p_neg = pn[NW-1] ^ sq[SQ_STEPS].den_neg;
		dv[0].m_neg = mn[NW-1] ^ sq[SQ_STEPS].den_neg;
		dv[0].p_num = {pmag, 16'b0};
		dv[0].m_num = {mmag, 16'b0};
		dv[0].p_rem = '0;
		dv[0].m_rem = '0;
		dv[0].p_quo = '0;
		dv[0].m_quo = '0;
	end

	for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
		qrs_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .din(dv[j]), .dout(dv[j+1])
		);
	end

	function automatic logic [RW-1:0] sat(input logic [QW-1:0] q, input logic neg);
		logic [RW-1:0] r;
		if (neg) begin
			r = (q > QW'(32'h8000_0000)) ? 32'h8000_0000 : RW'(-q);
		end else begin
			r = (q > QW'(32'h7fff_ffff)) ? 32'h7fff_ffff : q[RW-1:0];
		end
		return r;
	endfunction

	always_comb begin
		rp = sat(dv[DV_STEPS].p_quo, dv[DV_STEPS].p_neg);
		rm = sat(dv[DV_STEPS].m_quo, dv[DV_STEPS].m_neg);
		if (dv[DV_STEPS].status == ST_NONE || dv[DV_STEPS].status == ST_NOTQ) begin
			rp = '0;
			rm = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv[DV_STEPS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {rm, rp, dv[DV_STEPS].status};
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {6'b0, data_q};

`ifndef SYNTHESIS
	a_double_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == ST_ONE |-> m_axis_tdata[33:2] == m_axis_tdata[65:34])
		else $error("double root with differing roots");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == ST_NONE || m_axis_tdata[1:0] == ST_NOTQ)
		|-> m_axis_tdata[65:2] == '0)
		else $error("roots not zero without real roots");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dv[DV_STEPS].vld))
		else $error("pipeline moved during stall");
`endif

endmodule
